// ===== hw/rtl/u2u_pkg.sv =====
// shared types and constants for the utf-8 to 16-bit code unit decoder
// no dependencies
`timescale 1ns / 1ps

package u2u_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_u2u_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
    } t_u2u_out;

    // one beat's worth of results, one or two code units
    typedef struct packed {
        logic        two;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_u2u_entry;

endpackage

// ===== hw/rtl/u2u_front.sv =====
// front end: sequence state, byte classification, builds at most one queue entry per beat
// depends on u2u_pkg
`timescale 1ns / 1ps

module u2u_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  u2u_pkg::t_u2u_in    i_item,
    output logic                o_push,
    output u2u_pkg::t_u2u_entry o_entry
);
    import u2u_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TWO_1   = 3'd1,
        PH_THREE_2 = 3'd2,
        PH_THREE_1 = 3'd3,
        PH_FOUR_LD = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pv, n_pv;
    logic [1:0]  cnt;
    logic [15:0] u0, u1;
    logic        fresh;
    logic        cont;
    logic [7:0]  b;

    assign b    = i_item.in_byte;
    assign cont = (b[7:6] == 2'b10);

    always_comb begin
        n_phase = r_phase;
        n_pv    = r_pv;
        fresh   = 1'b1;
        cnt     = 2'd0;
        u0      = 16'h0000;
        u1      = 16'h0000;

        unique case (r_phase)
            PH_TWO_1, PH_THREE_1: begin
                u0      = cont ? (r_pv | {10'd0, b[5:0]}) : r_pv;
                cnt     = 2'd1;
                fresh   = !cont;
                n_phase = PH_IDLE;
                n_pv    = 16'h0000;
            end
            PH_THREE_2: begin
                if (cont) begin
                    n_pv    = r_pv | {4'd0, b[5:0], 6'd0};
                    n_phase = PH_THREE_1;
                    fresh   = 1'b0;
                end else begin
                    u0      = r_pv;
                    cnt     = 2'd1;
                    n_phase = PH_IDLE;
                    n_pv    = 16'h0000;
                end
            end
            PH_FOUR_LD: begin
                if (cont) begin
                    n_pv    = {b[3:0], 12'd0};
                    n_phase = PH_THREE_2;
                    fresh   = 1'b0;
                end else begin
                    u0      = 16'h0000;
                    cnt     = 2'd1;
                    n_phase = PH_IDLE;
                    n_pv    = 16'h0000;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_pv    = 16'h0000;
            end
        endcase

        if (fresh) begin
            if (b[7] == 1'b0) begin
                if (cnt == 2'd0) u0 = {8'h00, b};
                else             u1 = {8'h00, b};
                cnt = cnt + 2'd1;
            end else if (b[7:5] == 3'b110) begin
                n_pv    = {5'd0, b[4:0], 6'd0};
                n_phase = PH_TWO_1;
            end else if (b[7:4] == 4'b1110) begin
                n_pv    = {b[3:0], 12'd0};
                n_phase = PH_THREE_2;
            end else if (b[7:3] == 5'b11110) begin
                n_pv    = 16'h0000;
                n_phase = PH_FOUR_LD;
            end else begin
                if (cnt == 2'd0) u0 = {8'hFF, b};
                else             u1 = {8'hFF, b};
                cnt = cnt + 2'd1;
            end
        end

        // flush at stream end
        if (i_item.stream_end && (n_phase != PH_IDLE)) begin
            if (cnt == 2'd0) u0 = (n_phase == PH_FOUR_LD) ? 16'h0000 : n_pv;
            else             u1 = (n_phase == PH_FOUR_LD) ? 16'h0000 : n_pv;
            cnt     = cnt + 2'd1;
            n_phase = PH_IDLE;
            n_pv    = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pv    <= 16'h0000;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pv    <= n_pv;
        end
    end

    assign o_push      = i_accept && (cnt != 2'd0);
    assign o_entry.two = (cnt == 2'd2);
    assign o_entry.u0  = u0;
    assign o_entry.u1  = u1;

    // two code units need a sequence pending before the beat
    a_two_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt == 2'd2) |-> (r_phase != PH_IDLE))
        else $error("two results from idle phase");

    a_no_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt != 2'd3)
        else $error("more than two results in one beat");

    a_idle_clears_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_pv == 16'h0000))
        else $error("partial value left over in idle");

endmodule

// ===== hw/rtl/u2u_queue.sv =====
// small queue of result entries between front and back end
// depends on u2u_pkg
`timescale 1ns / 1ps

module u2u_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u2u_pkg::t_u2u_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output u2u_pkg::t_u2u_entry o_entry
);
    import u2u_pkg::*;

    t_u2u_entry     r_mem [QDepth];
    logic [QAw-1:0] r_wr, r_rd;
    logic [QAw:0]   r_count;

    assign o_full  = (r_count == QDepth[QAw:0]);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QDepth[QAw:0])
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/u2u_back.sv =====
// back end: splits queue entries into single code units, registered result
// depends on u2u_pkg
`timescale 1ns / 1ps

module u2u_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  u2u_pkg::t_u2u_entry i_q_entry,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output u2u_pkg::t_u2u_out   o_result
);
    import u2u_pkg::*;

    logic     r_valid;
    logic     r_sel;
    t_u2u_out r_out;
    logic     load;
    logic     first_of_two;

    assign load         = i_q_valid && (!r_valid || i_pop);
    assign first_of_two = i_q_entry.two && !r_sel;
    assign o_q_pop      = load && !first_of_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= first_of_two;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.code_unit <= r_sel ? i_q_entry.u1 : i_q_entry.u0;
            r_out.run_last  <= !first_of_two;
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

    // second half of an entry is still in the queue
    a_sel_holds_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_q_valid && i_q_entry.two))
        else $error("split entry lost from queue");

    a_sel_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sel && r_valid) |-> !r_out.run_last)
        else $error("first unit of pair marked last");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out.run_last)
        else $error("entry retired without last unit");

endmodule

// ===== hw/rtl/utf8_to_utf16_decoder.sv =====
// utf-8 byte stream to 16-bit code unit decoder, top level
// path: a byte's result is written into a queue entry, then into the result register
// throughput: one byte per cycle unless the queue is full; one code unit leaves per cycle
// as popped; a two-unit byte holds the output side for both, absorbed by a 4-entry queue
// reset: synchronous active-low; clears sequence state, queue pointers and result valid flag
// depends on u2u_pkg, u2u_front, u2u_queue, u2u_back
`timescale 1ns / 1ps

module utf8_to_utf16_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  u2u_pkg::t_u2u_in   i_item,
    output logic               empty,
    input  logic               pop,
    output u2u_pkg::t_u2u_out  o_result
);
    import u2u_pkg::*;

    logic       accept;
    logic       f_push;
    t_u2u_entry f_entry;
    logic       q_valid;
    logic       q_pop;
    t_u2u_entry q_entry;

    assign accept = push && !full;

    u2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (f_push),
        .o_entry  (f_entry)
    );

    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    u2u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule
